// ===== hdl/assert_macros.svh =====
// Assertion macros for the compress and pack RTL, included by the pack stage.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define MLKCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define MLKCP_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/mlkcp_pkg.sv =====
// Constants, types and helpers for the ML-KEM coefficient compress and pack block.
package mlkcp_pkg;

	localparam int COEFS_PER_POLY = 256;
	localparam int LANES          = 4;
	localparam int INPUT_FIELDS   = 4;
	localparam int ACTIVE_LANES   = (LANES < INPUT_FIELDS) ? LANES : INPUT_FIELDS;
	localparam int ITEMS_RAW      = COEFS_PER_POLY / LANES;
	localparam int ITEMS_PER_POLY = (ITEMS_RAW > 0) ? ITEMS_RAW : 1;
	localparam int GRP_W          = (ITEMS_PER_POLY > 1) ? $clog2(ITEMS_PER_POLY) : 1;

	localparam int COEF_W   = 12;
	localparam int D_MAX    = 11;
	localparam int NUM_W    = COEF_W + D_MAX;
	localparam int RECIP_W  = 15;
	localparam int PROD_W   = NUM_W + RECIP_W;
	localparam int QEST_W   = 12;
	localparam int CHK_W    = QEST_W + 12;
	localparam int RES_W    = 7;
	localparam int NRES_W   = 3;
	localparam int FIELD_W  = ACTIVE_LANES * D_MAX;
	localparam int TOT_W    = $clog2(RES_W + FIELD_W + 1);
	localparam int OUT_BYTES = 6;
	localparam int OUT_W    = OUT_BYTES * 8;
	localparam int CNT_W    = 3;
	localparam int ACC_W    = OUT_W + 8;
	localparam int IN_W     = INPUT_FIELDS * COEF_W;
	localparam int OUT_TDATA_W = ((OUT_W + CNT_W + 7) / 8) * 8;

	localparam logic [COEF_W-1:0]  MOD_Q       = 12'd3329;
	localparam logic [NUM_W-1:0]   HALF_Q      = NUM_W'(1664);
	localparam logic [RECIP_W-1:0] RECIP_Q     = 15'd20159;
	localparam int                 RECIP_SHIFT = 26;

	localparam logic [1:0] MODE_D4  = 2'd0;
	localparam logic [1:0] MODE_D5  = 2'd1;
	localparam logic [1:0] MODE_D10 = 2'd2;
	localparam logic [1:0] MODE_D11 = 2'd3;

	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [D_MAX-1:0]  code_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} pipe_ctl_t;

	function automatic logic [3:0] code_width(input logic [1:0] mode);
		logic [3:0] d;
		unique case (mode)
			MODE_D4:  d = 4'd4;
			MODE_D5:  d = 4'd5;
			MODE_D10: d = 4'd10;
			MODE_D11: d = 4'd11;
			default:  d = 4'd4;
		endcase
		return d;
	endfunction

	function automatic logic [TOT_W-1:0] lane_bits(input logic [1:0] mode);
		logic [TOT_W-1:0] b;
		unique case (mode)
			MODE_D4:  b = TOT_W'(ACTIVE_LANES * 4);
			MODE_D5:  b = TOT_W'(ACTIVE_LANES * 5);
			MODE_D10: b = TOT_W'(ACTIVE_LANES * 10);
			MODE_D11: b = TOT_W'(ACTIVE_LANES * 11);
			default:  b = TOT_W'(ACTIVE_LANES * 4);
		endcase
		return b;
	endfunction

endpackage

// ===== hdl/mlkcp_lane.sv =====
// One compression lane: round(x * 2^d / q) by reciprocal multiply and one correction.
module mlkcp_lane
	import mlkcp_pkg::*;
(
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  logic [1:0] mode,
	input  coef_t     coef,
	output code_t     code,
	output logic      err
);

	logic [NUM_W-1:0]  num;
	logic [PROD_W-1:0] prod;
	logic [NUM_W-1:0]  num_s1;
	logic [QEST_W-1:0] qest_s1;
	logic              err_s1;
	logic [CHK_W-1:0]  chk;
	logic [QEST_W-1:0] quot;
	code_t             mask;
	code_t             code_s2;
	logic              err_s2;

	assign num  = (NUM_W'(coef) << code_width(mode)) + HALF_Q;
	assign prod = PROD_W'(num) * PROD_W'(RECIP_Q);

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			num_s1  <= num;
			qest_s1 <= prod[RECIP_SHIFT +: QEST_W];
			err_s1  <= (coef >= MOD_Q);
		end
	end

	// estimate is exact or one high
	assign chk  = CHK_W'(qest_s1) * CHK_W'(MOD_Q);
	assign quot = (chk > CHK_W'(num_s1)) ? qest_s1 - 1'b1 : qest_s1;
	assign mask = code_t'((D_MAX+1)'(1) << code_width(mode)) - 1'b1;

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			code_s2 <= quot[D_MAX-1:0] & mask;
			err_s2  <= err_s1;
		end
	end

	assign code = code_s2;
	assign err  = err_s2;

endmodule

// ===== hdl/mlkcp_pack.sv =====
// Merge stage: packs lane codes onto the bit reservoir and registers the output beat.
`include "assert_macros.svh"
module mlkcp_pack
	import mlkcp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       mode,
	input  logic             ld,
	input  logic             in_valid,
	input  code_t            codes [ACTIVE_LANES],
	input  logic [ACTIVE_LANES-1:0] errs,
	output logic             out_valid,
	output logic [OUT_W-1:0] out_bytes,
	output logic [CNT_W-1:0] out_count,
	output logic             out_last,
	output logic             out_err
);

	logic [RES_W-1:0]   res_q;
	logic [NRES_W-1:0]  nres_q;
	logic [GRP_W-1:0]   grp_q;
	logic               valid_s3;
	logic [OUT_W-1:0]   bytes_s3;
	logic [CNT_W-1:0]   cnt_s3;
	logic               last_s3;
	logic               err_s3;

	logic [FIELD_W-1:0] field;
	logic [ACC_W-1:0]   acc;
	logic [TOT_W-1:0]   total;
	logic [CNT_W-1:0]   cnt;
	logic [OUT_W-1:0]   packed_c;
	logic [RES_W-1:0]   rem;
	logic               last_c;
	logic               commit;

	always_comb begin
		field = '0;
		for (int i = 0; i < ACTIVE_LANES; i++) begin
			unique case (mode)
				MODE_D4:  field[i*4 +: 4]   = codes[i][3:0];
				MODE_D5:  field[i*5 +: 5]   = codes[i][4:0];
				MODE_D10: field[i*10 +: 10] = codes[i][9:0];
				MODE_D11: field[i*11 +: 11] = codes[i][10:0];
				default:  field[i*4 +: 4]   = codes[i][3:0];
			endcase
		end
	end

	assign acc   = ACC_W'(res_q) | (ACC_W'(field) << nres_q);
	assign total = TOT_W'(nres_q) + lane_bits(mode);
	assign cnt   = CNT_W'(total >> 3);
	assign rem   = acc[{cnt, 3'b000} +: RES_W];

	always_comb begin
		packed_c = '0;
		for (int k = 0; k < OUT_BYTES; k++) begin
			if (CNT_W'(k) < cnt)
				packed_c[k*8 +: 8] = acc[k*8 +: 8];
		end
	end

	assign last_c = (grp_q == GRP_W'(ITEMS_PER_POLY - 1));
	assign commit = ld && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q    <= '0;
			nres_q   <= '0;
			grp_q    <= '0;
			valid_s3 <= 1'b0;
		end else begin
			if (ld)
				valid_s3 <= in_valid;
			if (commit) begin
				if (last_c) begin
					res_q  <= '0;
					nres_q <= '0;
					grp_q  <= '0;
				end else begin
					res_q  <= rem;
					nres_q <= total[NRES_W-1:0];
					grp_q  <= grp_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			bytes_s3 <= packed_c;
			cnt_s3   <= cnt;
			last_s3  <= last_c;
			err_s3   <= |errs;
		end
	end

	assign out_valid = valid_s3;
	assign out_bytes = bytes_s3;
	assign out_count = cnt_s3;
	assign out_last  = last_s3;
	assign out_err   = err_s3;

	`MLKCP_ASSERT(a_res_clear_after_last, (commit && last_c) |=> (res_q == '0 && nres_q == '0), "reservoir not cleared after polynomial end")
	`MLKCP_ASSERT(a_res_upper_zero, (RES_W'(res_q >> nres_q) == '0), "reservoir holds bits above its count")
	`MLKCP_ASSERT(a_count_range, valid_s3 |-> (cnt_s3 <= CNT_W'(OUT_BYTES)), "byte count above six")
	`MLKCP_ASSERT(a_bytes_above_count, valid_s3 |-> ((bytes_s3 >> {cnt_s3, 3'b000}) == '0), "bytes beyond count not zero")

endmodule

// ===== hdl/mlkem_coefficient_compress_pack.sv =====
// ML-KEM coefficient compressor and little-endian bit packer, top level.
// Pipeline: an accepted input beat passes two lane stages and one merge to its output beat.
// Throughput: one beat per clock while m_tready allows; reservoir update is combinational.
// Backpressure stalls only full stages; bubbles are filled while an output beat waits.
// Reset (arst_n low, asynchronous): width mode 4 bits, reservoir and polynomial count cleared,
// pipeline emptied.
module mlkem_coefficient_compress_pack
	import mlkcp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_W-1:0]        s_tdata,  // coef_0, coef_1, coef_2, coef_3
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // packed_bytes, byte_count, zero pad
	output logic                   m_tlast,
	output logic [0:0]             m_tuser   // range_error
);

	logic [1:0]              width_mode_q;
	logic                    v_s1;
	logic                    v_s2;
	logic                    en_s3;
	pipe_ctl_t               ctl;
	code_t                   codes [ACTIVE_LANES];
	logic [ACTIVE_LANES-1:0] errs;
	logic                    out_valid;
	logic [OUT_W-1:0]        out_bytes;
	logic [CNT_W-1:0]        out_count;
	logic                    out_last;
	logic                    out_err;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			width_mode_q <= MODE_D4;
		else if (cfg_valid && cfg_ready)
			width_mode_q <= cfg_data;
	end

	assign en_s3      = !out_valid || m_tready;
	assign ctl.en_s2  = !v_s2 || en_s3;
	assign ctl.en_s1  = !v_s1 || ctl.en_s2;
	assign s_tready   = ctl.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ctl.en_s1)
				v_s1 <= s_tvalid;
			if (ctl.en_s2)
				v_s2 <= v_s1;
		end
	end

	for (genvar i = 0; i < ACTIVE_LANES; i++) begin : g_lane
		mlkcp_lane u_lane (
			.clk  (clk),
			.ctl  (ctl),
			.mode (width_mode_q),
			.coef (s_tdata[i*COEF_W +: COEF_W]),
			.code (codes[i]),
			.err  (errs[i])
		);
	end

	mlkcp_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (width_mode_q),
		.ld        (en_s3),
		.in_valid  (v_s2),
		.codes     (codes),
		.errs      (errs),
		.out_valid (out_valid),
		.out_bytes (out_bytes),
		.out_count (out_count),
		.out_last  (out_last),
		.out_err   (out_err)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = OUT_TDATA_W'({out_count, out_bytes});
	assign m_tlast  = out_last;
	assign m_tuser  = out_err;

endmodule
